// ===== rtl/core/wsfd_pkg.sv =====
// types, constants and helpers shared by the websocket frame deframer
package wsfd_pkg;

    // header field masks and length escape codes
    localparam logic [7:0] HDR_FIN_MASK  = 8'h80;
    localparam logic [7:0] HDR_LEN_MASK  = 8'h7f;
    localparam logic [6:0] LEN_EXT16     = 7'd126;
    localparam logic [6:0] LEN_EXT64     = 7'd127;

    // opcodes that produce payload beats
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    // frame kind codes on the output
    localparam logic [2:0] KIND_TEXT   = 3'd0;
    localparam logic [2:0] KIND_BINARY = 3'd1;
    localparam logic [2:0] KIND_PING   = 3'd2;
    localparam logic [2:0] KIND_PONG   = 3'd3;
    localparam logic [2:0] KIND_CLOSE  = 3'd4;

    // extended length: index of the first byte of a 16-bit length, last index
    localparam logic [2:0] EXT_IDX_16   = 3'd6;
    localparam logic [2:0] EXT_IDX_LAST = 3'd7;
    localparam logic [1:0] KEY_IDX_LAST = 2'd3;

    typedef enum logic [2:0] {
        PH_HDR,
        PH_LEN,
        PH_EXT,
        PH_KEY,
        PH_DATA
    } t_phase;

    typedef struct packed {
        logic       valid;
        logic [7:0] out_byte;
        logic [2:0] frame_kind;
        logic       fin_flag;
        logic       last_of_frame;
    } t_result;

    typedef struct packed {
        logic       known;
        logic [2:0] kind;
    } t_kind;

    // opcode to frame kind; unknown opcodes are dropped
    function automatic t_kind kind_of(input logic [3:0] op);
        t_kind k;
        k.known = 1'b1;
        k.kind  = KIND_TEXT;
        case (op)
            OP_TEXT:   k.kind = KIND_TEXT;
            OP_BINARY: k.kind = KIND_BINARY;
            OP_PING:   k.kind = KIND_PING;
            OP_PONG:   k.kind = KIND_PONG;
            OP_CLOSE:  k.kind = KIND_CLOSE;
            default:   k.known = 1'b0;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/core/wsfd_parser.sv =====
// frame header parser and payload unmasking, one byte per cycle while i_en is high
module wsfd_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,       // byte accepted this cycle
    input  logic [7:0]        i_byte,
    output wsfd_pkg::t_result o_res       // result for the byte on i_byte
);
    import wsfd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_idx, n_idx;
    logic        r_fin, n_fin;
    logic [3:0]  r_opcode, n_opcode;
    logic        r_mask_on, n_mask_on;
    logic [63:0] r_len, n_len;        // length, then remaining bytes in payload
    logic [1:0]  r_pos, n_pos;        // key byte position
    logic [31:0] r_key, n_key;

    logic [6:0]  len7;
    logic        len_zero;
    logic        data_last;
    t_kind       kind;
    t_phase      after_len;
    logic [7:0]  key_byte;

    assign len7      = i_byte[6:0] & HDR_LEN_MASK[6:0];
    assign len_zero  = (r_len == 64'd0);
    assign data_last = (r_len == 64'd1);
    assign kind      = kind_of(r_opcode);

    // phase after the length is complete
    always_comb begin
        if (n_mask_on) begin
            after_len = PH_KEY;
        end else if (n_len == 64'd0) begin
            after_len = PH_HDR;
        end else begin
            after_len = PH_DATA;
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        case (r_phase)
            PH_HDR: begin
                n_phase = PH_LEN;
                n_idx   = '0;
            end
            PH_LEN: begin
                if (len7 == LEN_EXT16) begin
                    n_phase = PH_EXT;
                    n_idx   = EXT_IDX_16;
                end else if (len7 == LEN_EXT64) begin
                    n_phase = PH_EXT;
                    n_idx   = '0;
                end else begin
                    n_phase = after_len;
                    n_idx   = '0;
                end
            end
            PH_EXT: begin
                if (r_idx == EXT_IDX_LAST) begin
                    n_phase = after_len;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            PH_KEY: begin
                if (r_idx[1:0] == KEY_IDX_LAST) begin
                    n_phase = len_zero ? PH_HDR : PH_DATA;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            PH_DATA: begin
                if (data_last) begin
                    n_phase = PH_HDR;
                end
            end
            default: begin
                n_phase = PH_LEN;
                n_idx   = '0;
            end
        endcase
    end

    // header fields, length, key and payload result
    always_comb begin
        n_fin     = r_fin;
        n_opcode  = r_opcode;
        n_mask_on = r_mask_on;
        n_len     = r_len;
        n_pos     = r_pos;
        n_key     = r_key;
        key_byte  = r_key[31:24];
        o_res     = '0;
        case (r_phase)
            PH_HDR: begin
                n_fin     = |(i_byte & HDR_FIN_MASK);
                n_opcode  = i_byte[3:0];
                n_mask_on = 1'b0;
                n_len     = '0;
                n_pos     = '0;
                n_key     = '0;
            end
            PH_LEN: begin
                n_mask_on = |(i_byte & HDR_FIN_MASK);
                if (len7 != LEN_EXT16 && len7 != LEN_EXT64) begin
                    n_len = {57'd0, len7};
                end
            end
            PH_EXT: begin
                n_len = {r_len[55:0], i_byte};
            end
            PH_KEY: begin
                n_key = {r_key[23:0], i_byte};
            end
            PH_DATA: begin
                case (r_pos)
                    2'd0:    key_byte = r_key[31:24];
                    2'd1:    key_byte = r_key[23:16];
                    2'd2:    key_byte = r_key[15:8];
                    default: key_byte = r_key[7:0];
                endcase
                n_len                = r_len - 64'd1;
                n_pos                = r_pos + 2'd1;
                o_res.valid          = kind.known;
                o_res.out_byte       = i_byte ^ key_byte;
                o_res.frame_kind     = kind.kind;
                o_res.fin_flag       = r_fin;
                o_res.last_of_frame  = data_last;
            end
            default: begin
                n_fin     = |(i_byte & HDR_FIN_MASK);
                n_opcode  = i_byte[3:0];
                n_mask_on = 1'b0;
                n_len     = '0;
                n_pos     = '0;
                n_key     = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR;
            r_idx   <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
        end
    end

    // header and payload context, loaded or cleared at every accepted header byte
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fin     <= n_fin;
            r_opcode  <= n_opcode;
            r_mask_on <= n_mask_on;
            r_len     <= n_len;
            r_pos     <= n_pos;
            r_key     <= n_key;
        end
    end

    // payload phase always has bytes left to take
    a_data_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_len != 64'd0))
        else $error("payload phase with zero bytes remaining");

    // a frame-closing beat returns the parser to the header
    a_last_to_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_res.valid && o_res.last_of_frame) |=> (r_phase == PH_HDR))
        else $error("parser not back at header after last payload byte");

    // key index stays within four bytes
    a_key_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_KEY) |-> (r_idx[2] == 1'b0))
        else $error("masking key index out of range");

    // header byte always leads to the length byte
    a_hdr_to_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_phase == PH_HDR) |=> (r_phase == PH_LEN))
        else $error("header byte not followed by length phase");

endmodule

// ===== rtl/core/websocket_frame_deframer_top.sv =====
// websocket frame deframer: byte stream in, unmasked payload beats out
//
// The slave channel takes the received stream one byte per beat. Frame
// headers, extended lengths and masking keys are absorbed; each payload
// byte of a text, binary, ping, pong or close frame leaves as one master
// beat carrying the unmasked byte, the frame kind and FIN in tuser, and
// tlast on the final payload byte of the frame. Continuation frames,
// reserved opcodes and zero-length frames give no beats.
// Throughput: one byte per cycle while the master side is not stalled, set by
// the phase update and the 64-bit remaining-length decrement in the parser.
// A payload byte is registered as the slave side accepts it and is presented
// on the master side from the next cycle on.
// Reset (synchronous, active low) returns the parser to the start of a
// frame and empties the output register.
// When the receiver stalls, the held beat stays on the master side and
// s_axis_tready drops, so no byte is taken until the beat is delivered;
// a beat taken in the same cycle frees the register for the next one.
module websocket_frame_deframer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [3:0] m_axis_tuser,   // [2:0] frame_kind, [3] fin_flag
    output logic       m_axis_tlast    // last_of_frame
);
    import wsfd_pkg::*;

    logic    accept;
    t_result res;
    logic    r_valid;
    t_result r_res;

    // take a byte whenever the output register is free or being drained
    assign s_axis_tready = !r_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    wsfd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept),
        .i_byte  (s_axis_tdata),
        .o_res   (res)
    );

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= res.valid;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (accept && res.valid) begin
            r_res <= res;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_res.out_byte;
    assign m_axis_tuser  = {r_res.fin_flag, r_res.frame_kind};
    assign m_axis_tlast  = r_res.last_of_frame;

endmodule
